// ===== design/periodic_task_tick_scheduler_defines.svh =====
// Assertion macros shared by the scheduler modules.
`ifndef PERIODIC_TASK_TICK_SCHEDULER_DEFINES_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS
// Checks that a property holds at every clock edge outside of reset.
`define PTS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checks that a condition never becomes true outside of reset.
`define PTS_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define PTS_ASSERT(lbl, clk, rstn, prop, msg)
`define PTS_NEVER(lbl, clk, rstn, cond, msg)
`endif

`endif

// ===== design/pts_pkg.sv =====
`timescale 1ns / 1ps

package pts_pkg;

  localparam int unsigned NUM_SLOTS_DEF = 8;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_CREATE  = 3'd1;
  localparam logic [2:0] CMD_KILL    = 3'd2;
  localparam logic [2:0] CMD_SUSPEND = 3'd3;
  localparam logic [2:0] CMD_RESUME  = 3'd4;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_CREATE,
    OP_KILL,
    OP_SUSPEND,
    OP_RESUME
  } pts_op_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [2:0]  task_id;
    logic [15:0] period;
    logic [7:0]  first_delay;
  } pts_req_t;

  typedef struct packed {
    logic [2:0] fired_task;
    logic       last_fired;
  } pts_rsp_t;

  typedef struct packed {
    pts_op_e     op;
    logic [2:0]  task_id;
    logic [15:0] period;
    logic [7:0]  first_delay;
  } pts_entry_t;

  typedef struct packed {
    logic       valid;
    pts_entry_t entry;
  } pts_queue_t;

endpackage

// ===== design/pts_front.sv =====
`timescale 1ns / 1ps
`include "periodic_task_tick_scheduler_defines.svh"

module pts_front import pts_pkg::*; #(
  parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  pts_req_t   in_req_i,
  output pts_queue_t queue_o,
  input  logic       pop_i
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  pts_entry_t       entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  pts_entry_t       entry_new;
  logic             keep;
  logic             id_ok;
  logic             accept;
  logic             push;

  // Decode the command and drop anything that cannot change the slots.
  always_comb begin
    id_ok           = (32'(in_req_i.task_id) < NUM_SLOTS);
    entry_new.op          = OP_TICK;
    entry_new.task_id     = in_req_i.task_id;
    entry_new.period      = in_req_i.period;
    entry_new.first_delay = in_req_i.first_delay;
    keep            = 1'b0;
    case (in_req_i.cmd)
      CMD_TICK: begin
        entry_new.op = OP_TICK;
        keep         = 1'b1;
      end
      CMD_CREATE: begin
        entry_new.op = OP_CREATE;
        keep         = id_ok;
      end
      CMD_KILL: begin
        entry_new.op = OP_KILL;
        keep         = id_ok;
      end
      CMD_SUSPEND: begin
        entry_new.op = OP_SUSPEND;
        keep         = id_ok;
      end
      CMD_RESUME: begin
        entry_new.op = OP_RESUME;
        keep         = id_ok;
      end
      default: begin
        entry_new.op = OP_TICK;
        keep         = 1'b0;
      end
    endcase
  end

  assign in_stall_o = (count_q == CNT_W'(QUEUE_DEPTH));
  assign accept     = in_valid_i && !in_stall_o;
  assign push       = accept && keep;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (push && !pop_i) begin
      count_d = count_q + CNT_W'(1);
    end else if (!push && pop_i) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= entry_new;
    end
  end

  assign queue_o.valid = (count_q != '0);
  assign queue_o.entry = entries_q[rd_ptr_q];

  `PTS_NEVER(a_no_pop_empty, clk_i, rst_ni, pop_i && (count_q == '0), "pop from empty queue")
  `PTS_NEVER(a_count_range, clk_i, rst_ni, count_q > CNT_W'(QUEUE_DEPTH), "queue overfilled")
  `PTS_ASSERT(a_ptr_gap, clk_i, rst_ni,
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q), "pointers apart on empty queue")

endmodule

// ===== design/pts_back.sv =====
`timescale 1ns / 1ps
`include "periodic_task_tick_scheduler_defines.svh"

module pts_back import pts_pkg::*; #(
  parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  pts_queue_t queue_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output pts_rsp_t   out_rsp_o
);

  localparam int unsigned SLOT_IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } pts_state_e;

  pts_state_e         state_q, state_d;
  logic [NUM_SLOTS-1:0] valid_q, ready_q;
  logic [15:0]        period_q [NUM_SLOTS];
  logic [15:0]        count_q  [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] due_now;
  logic [NUM_SLOTS-1:0] due_q, due_d;
  logic [SLOT_IW-1:0] idx_q, idx_d;
  logic               out_valid_q, out_valid_d;
  pts_rsp_t           out_q, out_d;
  logic               out_free;
  logic               out_load;
  logic               do_tick;
  pts_entry_t         ent;

  assign ent = queue_i.entry;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      due_now[i] = valid_q[i] && ready_q[i] && (count_q[i] == 16'd0);
    end
  end

  assign pop_o    = queue_i.valid && (state_q == ST_IDLE);
  assign do_tick  = pop_o && (ent.op == OP_TICK);
  assign out_free = !out_valid_q || !out_stall_i;

  // Slot lanes: a tick updates every live, ready lane at once, other commands one lane.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ready_q <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        period_q[i] <= '0;
        count_q[i]  <= '0;
      end
    end else if (pop_o) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (ent.op == OP_TICK) begin
          if (valid_q[i] && ready_q[i]) begin
            if (count_q[i] == 16'd0) begin
              count_q[i] <= (period_q[i] == 16'd0) ? 16'd0 : period_q[i] - 16'd1;
            end else begin
              count_q[i] <= count_q[i] - 16'd1;
            end
          end
        end else if (32'(ent.task_id) == i) begin
          case (ent.op)
            OP_CREATE: begin
              valid_q[i]  <= 1'b1;
              ready_q[i]  <= 1'b1;
              period_q[i] <= ent.period;
              count_q[i]  <= {8'd0, ent.first_delay};
            end
            OP_KILL: begin
              valid_q[i]  <= 1'b0;
              ready_q[i]  <= 1'b0;
              period_q[i] <= '0;
              count_q[i]  <= '0;
            end
            OP_SUSPEND: ready_q[i] <= 1'b0;
            OP_RESUME:  ready_q[i] <= 1'b1;
            default: begin
            end
          endcase
        end
      end
    end
  end

  // Scan the slots that fired, lowest number first, one slot per cycle unless a due slot waits for the output register.
  always_comb begin
    state_d  = state_q;
    due_d    = due_q;
    idx_d    = idx_q;
    out_load = 1'b0;
    out_d.fired_task = 3'(idx_q);
    out_d.last_fired = ((due_q >> 1) == '0);
    case (state_q)
      ST_IDLE: begin
        if (do_tick && (due_now != '0)) begin
          state_d = ST_SCAN;
          due_d   = due_now;
          idx_d   = '0;
        end
      end
      ST_SCAN: begin
        if (!due_q[0] || out_free) begin
          out_load = due_q[0];
          due_d    = due_q >> 1;
          idx_d    = idx_q + SLOT_IW'(1);
          if ((due_q >> 1) == '0) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      due_q       <= '0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      due_q       <= due_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `PTS_ASSERT(a_scan_has_work, clk_i, rst_ni,
    (state_q == ST_SCAN) |-> (due_q != '0), "scan running with nothing due")
  `PTS_ASSERT(a_last_ends_scan, clk_i, rst_ni,
    (out_load && out_d.last_fired) |=> (state_q == ST_IDLE), "scan continues after last")
  `PTS_NEVER(a_load_over_full, clk_i, rst_ni, out_load && !out_free, "result overwritten")

endmodule

// ===== design/periodic_task_tick_scheduler.sv =====
`timescale 1ns / 1ps
// Order: an accepted request is written into the queue and reaches the slot table when the back
// pops it, only while idle; a create, kill, suspend or resume completes there on that pop. The
// first result of a tick passes the queue, the scan state and the output register. Throughput:
// one request per cycle while the queue drains. A tick holds the table while the scan walks
// from slot zero to the highest fired slot, and longer while the full output register waits.
// Reset: asynchronous, clears all slots, the request queue and the output at once.
`include "periodic_task_tick_scheduler_defines.svh"

module periodic_task_tick_scheduler import pts_pkg::*; #(
  parameter int unsigned NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  // Request channel: commands and ticks.
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  pts_req_t in_req_i,
  // Result channel: one result per fired slot.
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output pts_rsp_t out_rsp_o
);

  pts_queue_t queue;
  logic       pop;

  // The front decodes each request, discards those that cannot change any
  // slot (unused command codes, slot numbers outside the table) and queues
  // the rest, so new requests are taken, up to the queue depth, while a tick is still being scanned.
  pts_front #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .queue_o    (queue),
    .pop_i      (pop)
  );

  // The back holds the slot table. It executes one queued request at a time;
  // on a tick it captures which slots are due, updates every live, ready countdown
  // in the same cycle and then emits the due slots in ascending order, marking the
  // last one. The scan waits on a due slot while the output register is full and stalled.
  pts_back #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .queue_i     (queue),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  `PTS_NEVER(a_pop_needs_entry, clk_i, rst_ni, pop && !queue.valid, "pop without a request")
  `PTS_ASSERT(a_out_valid_held, clk_i, rst_ni,
    (out_valid_o && out_stall_i) |=> out_valid_o, "result dropped while stalled")
  `PTS_ASSERT(a_out_rsp_held, clk_i, rst_ni,
    (out_valid_o && out_stall_i) |=> $stable(out_rsp_o), "result changed while stalled")

endmodule

// ===== tb/tb_periodic_task_tick_scheduler.sv =====
`timescale 1ns / 1ps

module tb_periodic_task_tick_scheduler;
  import pts_pkg::*;

  // Command codes five to seven have no meaning and must leave the table alone.
  localparam logic [2:0] CMD_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] CMD_UNUSED_LAST  = 3'd7;

  localparam int unsigned SLOTS = NUM_SLOTS_DEF;

  // The longest correct stretch without any handshake is a sender gap plus a
  // receiver stall plus a full tick scan, well under the watchdog limit.
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  // A tick holds the table after it is accepted until its scan of the slots ends.
  localparam int unsigned DRAIN_CYCLES = 4 * SLOTS;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  pts_req_t in_req;
  logic     out_valid;
  logic     out_stall;
  pts_rsp_t out_rsp;

  // Local copy of the slot table, updated as each request is accepted.
  bit          slot_live  [SLOTS];
  bit          slot_armed [SLOTS];
  logic [15:0] slot_per   [SLOTS];
  logic [15:0] slot_cnt   [SLOTS];

  // Slot numbers that are due to come out, oldest first.
  pts_rsp_t expected_fires[$];

  int unsigned mismatches;
  int unsigned quiet_cycles;
  bit          idle_on;
  int unsigned stall_left;
  bit          stall_mode;

  periodic_task_tick_scheduler #(
    .NUM_SLOTS (SLOTS)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Every mismatch goes through here so that one line is printed and counted.
  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  function automatic pts_req_t make_req(input logic [2:0] cmd, input logic [2:0] id,
                                        input logic [15:0] per, input logic [7:0] dly);
    pts_req_t r;
    r.cmd         = cmd;
    r.task_id     = id;
    r.period      = per;
    r.first_delay = dly;
    return r;
  endfunction

  // Applies one accepted request to the local slot table. A tick walks the
  // slots in ascending order; each due slot is queued as a result and the
  // final one of the tick carries the last mark.
  task automatic apply_to_slot_table(input pts_req_t req);
    pts_rsp_t fired[$];
    pts_rsp_t r;
    if (req.cmd == CMD_TICK) begin
      for (int i = 0; i < SLOTS; i++) begin
        if (!slot_live[i] || !slot_armed[i]) continue;
        if (slot_cnt[i] == 16'd0) begin
          // A period of zero behaves as one: reload to zero, fire every tick.
          slot_cnt[i]  = (slot_per[i] == 16'd0) ? 16'd0 : slot_per[i] - 16'd1;
          r.fired_task = i[2:0];
          r.last_fired = 1'b0;
          fired.push_back(r);
        end else begin
          slot_cnt[i] = slot_cnt[i] - 16'd1;
        end
      end
      if (fired.size() > 0) fired[fired.size() - 1].last_fired = 1'b1;
      foreach (fired[k]) expected_fires.push_back(fired[k]);
    end else if (req.task_id < SLOTS) begin
      case (req.cmd)
        CMD_CREATE: begin
          slot_live[req.task_id]  = 1'b1;
          slot_armed[req.task_id] = 1'b1;
          slot_per[req.task_id]   = req.period;
          slot_cnt[req.task_id]   = {8'd0, req.first_delay};
        end
        CMD_KILL: begin
          slot_live[req.task_id]  = 1'b0;
          slot_armed[req.task_id] = 1'b0;
          slot_per[req.task_id]   = 16'd0;
          slot_cnt[req.task_id]   = 16'd0;
        end
        // Suspend and resume only touch the ready mark, even on a dead slot.
        CMD_SUSPEND: slot_armed[req.task_id] = 1'b0;
        CMD_RESUME:  slot_armed[req.task_id] = 1'b1;
        default: ;
      endcase
    end
  endtask

  // Sends one request. It is entered and left at a falling edge. When idling
  // is on, a random gap may come first; valid is only raised once per step
  // so that a back-to-back request never sees valid dip.
  task automatic send_request(input pts_req_t req);
    int unsigned gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (in_stall);
    apply_to_slot_table(req);
    @(negedge clk);
  endtask

  task automatic send_tick();
    send_request(make_req(CMD_TICK, 3'($urandom_range(0, 7)),
                          16'($urandom_range(0, 16'hffff)),
                          8'($urandom_range(0, 8'hff))));
  endtask

  // Creates with both period extremes and the largest first delay, then
  // ticks so that the short-period slots fire and the long one keeps counting.
  task automatic test_create_and_fire();
    send_request(make_req(CMD_CREATE, 3'd0, 16'd3, 8'd0));
    send_request(make_req(CMD_CREATE, 3'd7, 16'd0, 8'd2));
    send_request(make_req(CMD_CREATE, 3'd3, 16'hffff, 8'hff));
    repeat (3) send_tick();
  endtask

  // Suspend holds a countdown, resume restarts it, kill clears the slot.
  // Suspend and resume of dead slots must not bring them to life, and a
  // create on a live slot overwrites it.
  task automatic test_suspend_resume_kill();
    send_request(make_req(CMD_SUSPEND, 3'd0, 16'd0, 8'd0));
    send_tick();
    send_request(make_req(CMD_RESUME, 3'd0, 16'd0, 8'd0));
    send_request(make_req(CMD_KILL, 3'd7, 16'd0, 8'd0));
    send_tick();
    send_request(make_req(CMD_SUSPEND, 3'd5, 16'hffff, 8'hff));
    send_request(make_req(CMD_RESUME, 3'd6, 16'hffff, 8'hff));
    send_request(make_req(CMD_CREATE, 3'd0, 16'd1, 8'd0));
    send_tick();
  endtask

  // The unused codes carry all-ones fields; the tick after them shows
  // whether anything in the table moved.
  task automatic test_unused_commands();
    for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
      send_request(make_req(c[2:0], 3'd7, 16'hffff, 8'hff));
    send_tick();
  endtask

  // Every slot fires on the same tick, so the result burst is as long as it
  // can get and the last mark lands on the highest slot.
  task automatic test_full_table();
    for (int i = 0; i < SLOTS; i++)
      send_request(make_req(CMD_CREATE, i[2:0], 16'($urandom_range(0, 1)), 8'd0));
    repeat (2) send_tick();
  endtask

  // Mostly ticks and creates with short periods and delays so that slots
  // fire often; now and then full-range values, dead-slot commands and
  // unused codes are mixed in.
  task automatic test_random_traffic(input int unsigned count);
    int unsigned pick;
    logic [15:0] per;
    logic [7:0]  dly;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      per  = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(0, 16'hffff))
                                         : 16'($urandom_range(0, 6));
      dly  = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 8'hff))
                                         : 8'($urandom_range(0, 5));
      if (pick < 45)
        send_tick();
      else if (pick < 70)
        send_request(make_req(CMD_CREATE, 3'($urandom_range(0, 7)), per, dly));
      else if (pick < 78)
        send_request(make_req(CMD_KILL, 3'($urandom_range(0, 7)), per, dly));
      else if (pick < 86)
        send_request(make_req(CMD_SUSPEND, 3'($urandom_range(0, 7)), per, dly));
      else if (pick < 94)
        send_request(make_req(CMD_RESUME, 3'($urandom_range(0, 7)), per, dly));
      else
        send_request(make_req(3'($urandom_range(CMD_UNUSED_FIRST, CMD_UNUSED_LAST)),
                              3'($urandom_range(0, 7)), per, dly));
    end
  endtask

  // Receiver side: alternating random bursts of stall and of free flow while
  // idling is on, and a steady open channel otherwise.
  always @(negedge clk) begin
    if (!idle_on) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = ($urandom_range(0, 2) == 0);
        stall_left = stall_mode ? $urandom_range(1, 16) : $urandom_range(1, 24);
      end
      stall_left--;
      out_stall <= stall_mode;
    end
  end

  // Every accepted result must match the oldest outstanding one.
  always @(posedge clk) begin
    pts_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_fires.size() == 0) begin
        report_mismatch($sformatf("unexpected result slot %0d last %0b",
                                  out_rsp.fired_task, out_rsp.last_fired));
      end else begin
        want = expected_fires.pop_front();
        if (out_rsp.fired_task !== want.fired_task)
          report_mismatch($sformatf("fired_task %0d, want %0d",
                                    out_rsp.fired_task, want.fired_task));
        if (out_rsp.last_fired !== want.last_fired)
          report_mismatch($sformatf("last_fired %0b on slot %0d, want %0b",
                                    out_rsp.last_fired, want.fired_task, want.last_fired));
      end
    end
  end

  // Ends the run if neither channel completes a handshake for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("tb_periodic_task_tick_scheduler: FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req       = '0;
    out_stall    = 1'b0;
    idle_on      = 1'b0;
    mismatches   = 0;
    quiet_cycles = 0;
    stall_left   = 0;
    stall_mode   = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_live[i]  = 1'b0;
      slot_armed[i] = 1'b0;
      slot_per[i]   = 16'd0;
      slot_cnt[i]   = 16'd0;
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    idle_on = 1'b1;
    test_create_and_fire();
    test_suspend_resume_kill();
    test_unused_commands();
    test_full_table();
    test_random_traffic(100);
    // The closing stretch runs with both sides wide open.
    idle_on = 1'b0;
    test_random_traffic(30);
    in_valid <= 1'b0;

    while (expected_fires.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_fires.size() != 0)
      report_mismatch($sformatf("%0d results never came", expected_fires.size()));

    if (mismatches == 0) begin
      $display("tb_periodic_task_tick_scheduler: PASS");
    end else begin
      $display("tb_periodic_task_tick_scheduler: FAIL");
    end
    $finish;
  end

endmodule
